@@ design/v3a_pkg.sv @@
// Shared types and constants for the three-component vector ALU.
package v3a_pkg;

  // Default number of fractional bits in every component and scalar.
  localparam int FRAC_BITS_DEF = 16;

  // One root bit is resolved per square-root stage (64-bit radicand).
  localparam int SQRT_STAGES = 32;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_NEG    = 4'd2,
    CMD_SCALE  = 4'd3,
    CMD_DIVIDE = 4'd4,
    CMD_DOT    = 4'd5,
    CMD_CROSS  = 4'd6,
    CMD_MAG    = 4'd7,
    CMD_MAGSQ  = 4'd8,
    CMD_NORM   = 4'd9,
    CMD_EQUAL  = 4'd10
  } cmd_t;

  // Per-item sideband that travels down the pipeline next to the datapath.
  typedef struct packed {
    cmd_t             cmd;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][31:0] res;
    logic [31:0]      scal;
    logic             eq;
    logic             dz;
    logic             ov;
    logic [2:0]       neg;
  } carry_t;

endpackage

@@ design/vector3_alu.sv @@
// Top level of the three-component fixed-point vector ALU.
//
// Each accepted item carries vectors A and B, a scalar and an opcode, and
// yields exactly one result item, in order. The block is fully pipelined
// and takes one item every cycle unless the output holds an unread result.
// An item passes through operand capture, 32x32 products, sums and
// rounding, then 32 square-root stages, one divisor setup stage, one
// divider stage per numerator bit (32 + FRAC_BITS) and the output register.
// Every item walks the full pipeline whatever its opcode. When a result
// sits unread at the output the whole pipeline holds, so in_ready is high
// only while the output is empty or out_ready is high. The tolerance
// register may be written at any time the block holds no items.
module vector3_alu #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] scale,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z,
  output logic signed [31:0] res_scalar,
  output logic               is_equal,
  output logic               div_zero,
  output logic               overflowed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int SQ_N  = v3a_pkg::SQRT_STAGES;
  localparam int SUM_W = 66;
  localparam logic signed [SUM_W-1:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic [NUM_W-1:0] Q_MAXP = NUM_W'(32'h7fff_ffff);
  localparam logic [NUM_W-1:0] Q_MAXN = NUM_W'(32'h8000_0000);

  // Round half up, drop the fraction bits and saturate; bit 32 flags overflow.
  function automatic logic [32:0] round_sat(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] r;
    r = (x + HALF) >>> FRAC_BITS;
    if (r > SUM_W'(v3a_pkg::MAX32)) begin
      return {1'b1, v3a_pkg::MAX32};
    end else if (r < SUM_W'(v3a_pkg::MIN32)) begin
      return {1'b1, v3a_pkg::MIN32};
    end
    return {1'b0, r[31:0]};
  endfunction

  // Tolerance register; the write port is always ready.
  logic [30:0] tol;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 31'd1;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  // The whole pipeline advances unless the output holds an unread result.
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: input capture.
  logic               v1;
  v3a_pkg::cmd_t      cmd1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];
  logic signed [31:0] s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1  <= v3a_pkg::cmd_t'(cmd);
      a1[0] <= a_x;
      a1[1] <= a_y;
      a1[2] <= a_z;
      b1[0] <= b_x;
      b1[1] <= b_y;
      b1[2] <= b_z;
      s1    <= scale;
    end
  end

  // Multiplier operand selection; lanes 3 to 5 only serve the cross product.
  logic signed [31:0] mx [6];
  logic signed [31:0] my [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mx[i] = a1[i];
      my[i] = a1[i];
    end
    mx[3] = a1[2];
    my[3] = b1[1];
    mx[4] = a1[0];
    my[4] = b1[2];
    mx[5] = a1[1];
    my[5] = b1[0];
    case (cmd1)
      v3a_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) my[i] = s1;
      end
      v3a_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) my[i] = b1[i];
      end
      v3a_pkg::CMD_CROSS: begin
        mx[0] = a1[1];
        my[0] = b1[2];
        mx[1] = a1[2];
        my[1] = b1[0];
        mx[2] = a1[0];
        my[2] = b1[1];
      end
      default: begin
      end
    endcase
  end

  // Add, subtract, negate and the tolerance compare finish in stage 1.
  v3a_pkg::carry_t c1;

  always_comb begin
    logic signed [32:0] ea;
    logic signed [32:0] eb;
    logic signed [32:0] t;
    logic signed [32:0] dd;
    logic [32:0]        dabs;
    c1     = '0;
    c1.cmd = cmd1;
    c1.s   = s1;
    c1.eq  = (cmd1 == v3a_pkg::CMD_EQUAL);
    for (int i = 0; i < 3; i++) begin
      ea      = $signed({a1[i][31], a1[i]});
      eb      = $signed({b1[i][31], b1[i]});
      c1.a[i] = a1[i];
      dd      = ea - eb;
      case (cmd1)
        v3a_pkg::CMD_ADD: t = ea + eb;
        v3a_pkg::CMD_SUB: t = dd;
        v3a_pkg::CMD_NEG: t = -ea;
        default:          t = '0;
      endcase
      if (cmd1 inside {v3a_pkg::CMD_ADD, v3a_pkg::CMD_SUB, v3a_pkg::CMD_NEG}) begin
        if (t[32] != t[31]) begin
          c1.res[i] = t[32] ? v3a_pkg::MIN32 : v3a_pkg::MAX32;
          c1.ov     = 1'b1;
        end else begin
          c1.res[i] = t[31:0];
        end
      end
      dabs = dd[32] ? 33'(-dd) : 33'(dd);
      if (dabs > {2'b00, tol}) begin
        c1.eq = 1'b0;
      end
    end
  end

  // Stage 2: products.
  logic               v2;
  v3a_pkg::carry_t    c2;
  logic signed [63:0] m2 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c1;
      for (int i = 0; i < 6; i++) begin
        m2[i] <= mx[i] * my[i];
      end
    end
  end

  // Stage 3: exact lane sums and the three-term scalar sum.
  logic                    v3;
  v3a_pkg::carry_t         c3;
  logic signed [SUM_W-1:0] lane3 [3];
  logic signed [SUM_W-1:0] ssum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      for (int i = 0; i < 3; i++) begin
        lane3[i] <= (c2.cmd == v3a_pkg::CMD_CROSS) ?
                    SUM_W'(m2[i]) - SUM_W'(m2[i+3]) : SUM_W'(m2[i]);
      end
      ssum3 <= SUM_W'(m2[0]) + SUM_W'(m2[1]) + SUM_W'(m2[2]);
    end
  end

  // Stage 4: rounding and saturation of the product results.
  v3a_pkg::carry_t c3n;

  always_comb begin
    logic [32:0] rv;
    c3n = c3;
    for (int i = 0; i < 3; i++) begin
      rv = round_sat(lane3[i]);
      if (c3.cmd == v3a_pkg::CMD_SCALE || c3.cmd == v3a_pkg::CMD_CROSS) begin
        c3n.res[i] = rv[31:0];
        c3n.ov     = c3n.ov | rv[32];
      end
    end
    rv = round_sat(ssum3);
    if (c3.cmd == v3a_pkg::CMD_DOT || c3.cmd == v3a_pkg::CMD_MAGSQ) begin
      c3n.scal = rv[31:0];
      c3n.ov   = c3n.ov | rv[32];
    end
  end

  logic            v4;
  v3a_pkg::carry_t c4;
  logic [63:0]     sq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4  <= c3n;
      sq4 <= ssum3[63:0];
    end
  end

  // Square-root stages, with the sideband carried alongside.
  logic [31:0]     root;
  logic [SQ_N-1:0] vq;
  v3a_pkg::carry_t cq [SQ_N];

  v3a_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sq4),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[SQ_N-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cq[0] <= c4;
      for (int i = 1; i < SQ_N; i++) begin
        cq[i] <= cq[i-1];
      end
    end
  end

  // Divisor setup: magnitude result, divisor choice and operand magnitudes.
  v3a_pkg::carry_t  cpn;
  logic [31:0]      den_n;
  logic [NUM_W-1:0] num_n [3];

  always_comb begin
    logic [31:0] amag;
    logic        is_div;
    cpn    = cq[SQ_N-1];
    is_div = (cpn.cmd == v3a_pkg::CMD_DIVIDE);
    den_n  = is_div ? (cpn.s[31] ? -cpn.s : cpn.s) : root;
    if (cpn.cmd == v3a_pkg::CMD_MAG) begin
      cpn.scal = root[31] ? v3a_pkg::MAX32 : root;
      cpn.ov   = cpn.ov | root[31];
    end
    for (int i = 0; i < 3; i++) begin
      amag       = cpn.a[i][31] ? -cpn.a[i] : cpn.a[i];
      num_n[i]   = {amag, {FRAC_BITS{1'b0}}};
      cpn.neg[i] = cpn.a[i][31] ^ (is_div && cpn.s[31]);
    end
    cpn.dz = (is_div || cpn.cmd == v3a_pkg::CMD_NORM) && (den_n == 32'd0);
  end

  logic             vp;
  v3a_pkg::carry_t  cp;
  logic [31:0]      den_p;
  logic [NUM_W-1:0] num_p [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vq[SQ_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp    <= cpn;
      den_p <= den_n;
      for (int i = 0; i < 3; i++) begin
        num_p[i] <= num_n[i];
      end
    end
  end

  // Divider stages, one divider per component.
  logic [NUM_W-1:0] quo [3];
  logic [NUM_W-1:0] vd;
  v3a_pkg::carry_t  cd [NUM_W];

  for (genvar g = 0; g < 3; g++) begin : g_div
    v3a_div #(
      .NUM_W (NUM_W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num_p[g]),
      .den (den_p),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[NUM_W-2:0], vp};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= cp;
      for (int i = 1; i < NUM_W; i++) begin
        cd[i] <= cd[i-1];
      end
    end
  end

  // Quotient sign and saturation, or the divide-by-zero result.
  v3a_pkg::carry_t cf;

  always_comb begin
    cf = cd[NUM_W-1];
    if (cf.cmd == v3a_pkg::CMD_DIVIDE || cf.cmd == v3a_pkg::CMD_NORM) begin
      for (int i = 0; i < 3; i++) begin
        if (cf.dz) begin
          if (cf.a[i] == 32'd0) begin
            cf.res[i] = '0;
          end else begin
            cf.res[i] = cf.a[i][31] ? v3a_pkg::MIN32 : v3a_pkg::MAX32;
          end
        end else if (cf.neg[i]) begin
          if (quo[i] > Q_MAXN) begin
            cf.res[i] = v3a_pkg::MIN32;
            cf.ov     = 1'b1;
          end else begin
            cf.res[i] = -quo[i][31:0];
          end
        end else begin
          if (quo[i] > Q_MAXP) begin
            cf.res[i] = v3a_pkg::MAX32;
            cf.ov     = 1'b1;
          end else begin
            cf.res[i] = quo[i][31:0];
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x      <= cf.res[0];
      res_y      <= cf.res[1];
      res_z      <= cf.res[2];
      res_scalar <= cf.scal;
      is_equal   <= cf.eq;
      div_zero   <= cf.dz;
      overflowed <= cf.ov;
    end
  end

  // A zero divisor never counts as an overflow or an equality result.
  a_dz_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> !overflowed && !is_equal)
    else $error("div_zero raised together with another flag");

  // A zero divisor gives only signed extremes or zero, and no scalar.
  a_dz_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |->
      (res_x == v3a_pkg::MAX32 || res_x == v3a_pkg::MIN32 || res_x == 32'sd0) &&
      (res_y == v3a_pkg::MAX32 || res_y == v3a_pkg::MIN32 || res_y == 32'sd0) &&
      (res_z == v3a_pkg::MAX32 || res_z == v3a_pkg::MIN32 || res_z == 32'sd0) &&
      res_scalar == 32'sd0)
    else $error("divide-by-zero result is not saturated");

  // An equality result carries no vector, scalar or overflow.
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |->
      res_x == 32'sd0 && res_y == 32'sd0 && res_z == 32'sd0 &&
      res_scalar == 32'sd0 && !overflowed)
    else $error("equality result has nonzero payload");

endmodule

@@ design/v3a_sqrt.sv @@
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module v3a_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  localparam int N = v3a_pkg::SQRT_STAGES;

  logic [N-2:0][63:0] v_q;
  logic [N-1:0][63:0] r_q;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] v_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign v_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
    end

    // Try the next root bit against what is left of the radicand.
    assign trial = r_in + BIT;
    assign take  = (v_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[i] <= take ? (r_in >> 1) + BIT : (r_in >> 1);
      end
    end

    // The last stage only needs the root, not the remainder.
    if (i < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          v_q[i] <= take ? v_in - trial : v_in;
        end
      end
    end
  end

  assign root = r_q[N-1][31:0];

endmodule

@@ design/v3a_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3a_div #(
  parameter int NUM_W = 48
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic [NUM_W-1:0] quo
);

  localparam int DEN_W = 32;

  logic [NUM_W-2:0][DEN_W-1:0] rem_q;
  logic [NUM_W-2:0][DEN_W-1:0] den_q;
  logic [NUM_W-1:0][NUM_W-1:0] nq_q;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign nq_in  = num;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign nq_in  = nq_q[k-1];
    end

    // Bring down the next numerator bit and subtract the divisor if it fits.
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        nq_q[k] <= {nq_in[NUM_W-2:0], ge};
      end
    end

    if (k < NUM_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo = nq_q[NUM_W-1];

endmodule
